// ----- rtl/float_square_root_newton_top_defines.svh -----
// Assertion helpers shared by the RTL
`ifndef FLOAT_SQUARE_ROOT_NEWTON_TOP_DEFINES_SVH
`define FLOAT_SQUARE_ROOT_NEWTON_TOP_DEFINES_SVH

// condition holds at every clock edge out of reset
`define FSQRT_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define FSQRT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/fsqrt_pkg.sv -----
`default_nettype none
package fsqrt_pkg;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NORM,
      ST_INIT,
      ST_DIV,
      ST_DIV_RND,
      ST_ALIGN,
      ST_SUM,
      ST_RND
   } state_type;

   localparam logic [63:0] SIGN_BIT     = 64'h8000_0000_0000_0000;
   localparam logic [62:0] EXP_ALL_ONES = 63'h7FF0_0000_0000_0000;
   localparam logic [63:0] QUIET_NAN    = 64'h7FF8_0000_0000_0000;
   localparam logic [15:0] TOP_MANT_MASK = 16'h000F;
   localparam logic [15:0] TOP_EXP_MASK  = 16'h7FE0;
   localparam logic [15:0] GUESS_BIAS    = 16'd512 << 4;
   localparam logic signed [12:0] EXP_BIAS = 13'sd1023;
   localparam logic signed [12:0] SUBN_EXP = -13'sd1022;
   // quotient bits produced by the long division
   localparam int unsigned QUO_BITS = 56;

endpackage
`default_nettype wire

// ----- rtl/float_square_root_newton_top.sv -----
`default_nettype none
// Double-precision square root by Newton iteration, y = (x / y + y) / 2.
//
// Input: raise start with req_operand_bits while busy is low; the transaction
// is taken at that clock edge and busy rises on the next cycle for a non-special
// operand. Output: rsp_valid pulses for one cycle with rsp_root_bits; the
// receiver cannot stall, so every result must be taken in that cycle.
//
// Zero, negative, NaN and infinity operands give their result in the cycle
// after acceptance and busy never rises. A positive subnormal is first
// normalized: its fraction shifts left one bit at a time, with the exponent
// decremented, until its leading bit is set.
// Each Newton step runs setup, then the shared one-bit-per-cycle restoring
// divider for 56 quotient bits, then quotient rounding, then align, add
// and round/halve/compare. At most MAX_ITERATIONS steps are run, and one
// item is in flight at a time.
//
// Reset (synchronous, active high) returns the sequencer to idle and drops
// rsp_valid; an item in progress is discarded.
module float_square_root_newton_top #(
   parameter int MAX_ITERATIONS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [63:0] req_operand_bits,
   output logic             rsp_valid,
   output logic [63:0]      rsp_root_bits
);
   `include "float_square_root_newton_top_defines.svh"

   localparam int ITER_W = (MAX_ITERATIONS > 1) ? $clog2(MAX_ITERATIONS) : 1;
   localparam int CNT_W  = $clog2(fsqrt_pkg::QUO_BITS);

   fsqrt_pkg::state_type state_ff, state_in;

   logic [52:0]        x_m_ff, x_m_in;
   logic signed [12:0] x_e_ff, x_e_in;
   logic [63:0]        y1_ff, y1_in;
   logic [63:0]        y2_ff, y2_in;
   logic [ITER_W-1:0]  iter_ff, iter_in;
   logic [54:0]        rem_ff, rem_in;
   logic [55:0]        quo_ff, quo_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [52:0]        q_m_ff, q_m_in;
   logic signed [12:0] q_e_ff, q_e_in;
   logic [52:0]        big_m_ff, big_m_in;
   logic signed [12:0] big_e_ff, big_e_in;
   logic [55:0]        sh_ff, sh_in;
   logic [55:0]        nrm_ff, nrm_in;
   logic signed [12:0] nrm_e_ff, nrm_e_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_root_ff, rsp_root_in;

   // operand classification at the request port
   logic [62:0] op_mag;
   logic        op_nan, op_zero, op_neg, op_inf, op_special;
   logic [63:0] special_val;
   logic [15:0] guess_hi;
   logic [63:0] guess_bits;

   assign op_mag  = req_operand_bits[62:0];
   assign op_nan  = op_mag > fsqrt_pkg::EXP_ALL_ONES;
   assign op_zero = op_mag == 63'd0;
   assign op_neg  = (req_operand_bits & fsqrt_pkg::SIGN_BIT) != 64'd0;
   assign op_inf  = op_mag == fsqrt_pkg::EXP_ALL_ONES;
   assign op_special = op_nan | op_zero | op_neg | op_inf;

   always_comb begin
      priority if (op_nan) begin
         special_val = req_operand_bits;
      end else if (op_zero) begin
         special_val = 64'd0;
      end else if (op_neg) begin
         special_val = fsqrt_pkg::QUIET_NAN;
      end else begin
         special_val = req_operand_bits;
      end
   end

   // first guess: halve exponent field (low bit dropped), add bias
   assign guess_hi = (req_operand_bits[63:48] & fsqrt_pkg::TOP_MANT_MASK)
                   | (((req_operand_bits[63:48] & fsqrt_pkg::TOP_EXP_MASK) >> 1)
                      + fsqrt_pkg::GUESS_BIAS);
   assign guess_bits = {guess_hi, req_operand_bits[47:0]};

   // current guess unpacked
   logic [52:0]        y_m;
   logic signed [12:0] y_e;
   assign y_m = {1'b1, y1_ff[51:0]};
   assign y_e = $signed({2'b00, y1_ff[62:52]}) - fsqrt_pkg::EXP_BIAS;

   // shared divider step: compare and subtract
   logic        div_ge;
   logic [54:0] div_diff;
   assign div_ge   = rem_ff >= {2'b00, y_m};
   assign div_diff = div_ge ? (rem_ff - {2'b00, y_m}) : rem_ff;

   // quotient normalize and round
   logic [52:0]        dq_m;
   logic               dq_g, dq_s;
   logic signed [12:0] dq_e;
   logic [53:0]        dq_r;
   always_comb begin
      if (quo_ff[55]) begin
         dq_m = quo_ff[55:3];
         dq_g = quo_ff[2];
         dq_s = quo_ff[1] | quo_ff[0] | (rem_ff != 55'd0);
         dq_e = x_e_ff - y_e;
      end else begin
         dq_m = quo_ff[54:2];
         dq_g = quo_ff[1];
         dq_s = quo_ff[0] | (rem_ff != 55'd0);
         dq_e = x_e_ff - y_e - 13'sd1;
      end
      dq_r = {1'b0, dq_m} + {53'd0, dq_g & (dq_s | dq_m[0])};
   end

   // alignment of the smaller addend
   logic               q_big;
   logic [52:0]        sm_m;
   logic [12:0]        al_d;
   logic [55:0]        al_wide, al_sh;
   logic               al_st;
   always_comb begin
      q_big = q_e_ff >= y_e;
      sm_m  = q_big ? y_m : q_m_ff;
      al_d  = q_big ? 13'(q_e_ff - y_e) : 13'(y_e - q_e_ff);
      al_wide = {sm_m, 3'b000};
      if (al_d >= 13'd56) begin
         al_sh = 56'd0;
         al_st = 1'b1;
      end else begin
         al_sh = al_wide >> al_d[5:0];
         al_st = (al_wide & ((56'd1 << al_d[5:0]) - 56'd1)) != 56'd0;
      end
   end

   // sum and one-bit normalize
   logic [56:0] sum_s;
   assign sum_s = {1'b0, big_m_ff, 3'b000} + {1'b0, sh_ff};

   // round, halve, pack, compare
   logic [52:0]        ar_m;
   logic [53:0]        ar_r;
   logic signed [12:0] ar_e;
   logic [63:0]        y_new;
   logic               iter_done;
   always_comb begin
      ar_m = nrm_ff[55:3];
      ar_r = {1'b0, ar_m} + {53'd0, nrm_ff[2] & (nrm_ff[1] | nrm_ff[0] | ar_m[0])};
      ar_e = ar_r[53] ? nrm_e_ff : (nrm_e_ff - 13'sd1);
      y_new = {1'b0, 11'(ar_e + fsqrt_pkg::EXP_BIAS),
               ar_r[53] ? ar_r[52:1] : ar_r[51:0]};
      iter_done = (y_new == y1_ff) || (y_new == y2_ff)
               || (iter_ff == ITER_W'(MAX_ITERATIONS - 1));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fsqrt_pkg::ST_IDLE: begin
            if (start && !op_special) begin
               state_in = (req_operand_bits[62:52] == 11'd0) ? fsqrt_pkg::ST_NORM
                                                              : fsqrt_pkg::ST_INIT;
            end
         end
         fsqrt_pkg::ST_NORM: begin
            if (x_m_ff[52]) state_in = fsqrt_pkg::ST_INIT;
         end
         fsqrt_pkg::ST_INIT:    state_in = fsqrt_pkg::ST_DIV;
         fsqrt_pkg::ST_DIV: begin
            if (cnt_ff == CNT_W'(fsqrt_pkg::QUO_BITS - 1)) state_in = fsqrt_pkg::ST_DIV_RND;
         end
         fsqrt_pkg::ST_DIV_RND: state_in = fsqrt_pkg::ST_ALIGN;
         fsqrt_pkg::ST_ALIGN:   state_in = fsqrt_pkg::ST_SUM;
         fsqrt_pkg::ST_SUM:     state_in = fsqrt_pkg::ST_RND;
         fsqrt_pkg::ST_RND: begin
            state_in = iter_done ? fsqrt_pkg::ST_IDLE : fsqrt_pkg::ST_INIT;
         end
         default:               state_in = fsqrt_pkg::ST_IDLE;
      endcase
   end

   // datapath register updates
   always_comb begin
      x_m_in = x_m_ff;   x_e_in = x_e_ff;
      y1_in = y1_ff;     y2_in = y2_ff;     iter_in = iter_ff;
      rem_in = rem_ff;   quo_in = quo_ff;   cnt_in = cnt_ff;
      q_m_in = q_m_ff;   q_e_in = q_e_ff;
      big_m_in = big_m_ff; big_e_in = big_e_ff; sh_in = sh_ff;
      nrm_in = nrm_ff;   nrm_e_in = nrm_e_ff;
      rsp_valid_in = 1'b0;
      rsp_root_in = rsp_root_ff;
      unique case (state_ff)
         fsqrt_pkg::ST_IDLE: begin
            if (start) begin
               if (req_operand_bits[62:52] == 11'd0) begin
                  x_m_in = {1'b0, req_operand_bits[51:0]};
                  x_e_in = fsqrt_pkg::SUBN_EXP;
               end else begin
                  x_m_in = {1'b1, req_operand_bits[51:0]};
                  x_e_in = $signed({2'b00, req_operand_bits[62:52]}) - fsqrt_pkg::EXP_BIAS;
               end
               y1_in   = guess_bits;
               y2_in   = guess_bits;
               iter_in = '0;
               if (op_special) begin
                  rsp_valid_in = 1'b1;
                  rsp_root_in  = special_val;
               end
            end
         end
         fsqrt_pkg::ST_NORM: begin
            if (!x_m_ff[52]) begin
               x_m_in = {x_m_ff[51:0], 1'b0};
               x_e_in = x_e_ff - 13'sd1;
            end
         end
         fsqrt_pkg::ST_INIT: begin
            rem_in = {2'b00, x_m_ff};
            cnt_in = '0;
         end
         fsqrt_pkg::ST_DIV: begin
            quo_in = {quo_ff[54:0], div_ge};
            rem_in = (cnt_ff == CNT_W'(fsqrt_pkg::QUO_BITS - 1)) ? div_diff
                                                                  : {div_diff[53:0], 1'b0};
            cnt_in = cnt_ff + CNT_W'(1);
         end
         fsqrt_pkg::ST_DIV_RND: begin
            q_m_in = dq_r[53] ? dq_r[53:1] : dq_r[52:0];
            q_e_in = dq_r[53] ? (dq_e + 13'sd1) : dq_e;
         end
         fsqrt_pkg::ST_ALIGN: begin
            big_m_in = q_big ? q_m_ff : y_m;
            big_e_in = q_big ? q_e_ff : y_e;
            sh_in    = {al_sh[55:1], al_sh[0] | al_st};
         end
         fsqrt_pkg::ST_SUM: begin
            if (sum_s[56]) begin
               nrm_in   = {sum_s[56:2], sum_s[1] | sum_s[0]};
               nrm_e_in = big_e_ff + 13'sd1;
            end else begin
               nrm_in   = sum_s[55:0];
               nrm_e_in = big_e_ff;
            end
         end
         fsqrt_pkg::ST_RND: begin
            if (iter_done) begin
               rsp_valid_in = 1'b1;
               rsp_root_in  = y_new;
            end else begin
               y2_in   = y1_ff;
               y1_in   = y_new;
               iter_in = iter_ff + ITER_W'(1);
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fsqrt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_m_ff <= x_m_in;     x_e_ff <= x_e_in;
      y1_ff <= y1_in;       y2_ff <= y2_in;     iter_ff <= iter_in;
      rem_ff <= rem_in;     quo_ff <= quo_in;   cnt_ff <= cnt_in;
      q_m_ff <= q_m_in;     q_e_ff <= q_e_in;
      big_m_ff <= big_m_in; big_e_ff <= big_e_in; sh_ff <= sh_in;
      nrm_ff <= nrm_in;     nrm_e_ff <= nrm_e_in;
      rsp_root_ff <= rsp_root_in;
   end

   assign busy          = state_ff != fsqrt_pkg::ST_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_root_bits = rsp_root_ff;

   // checks on the sequencer and datapath
   `FSQRT_ASSERT_IMPLY(a_div_rem_bound, clock, reset, (state_ff == fsqrt_pkg::ST_DIV),
                       (rem_ff < {1'b0, y_m, 1'b0}), "divider remainder out of range")
   `FSQRT_ASSERT_IMPLY(a_sum_normalized, clock, reset, (state_ff == fsqrt_pkg::ST_RND),
                       nrm_ff[55], "sum not normalized before rounding")
   `FSQRT_ASSERT_IMPLY(a_iter_cap, clock, reset, (state_ff != fsqrt_pkg::ST_IDLE),
                       (iter_ff <= ITER_W'(MAX_ITERATIONS - 1)), "iteration count past cap")

endmodule
`default_nettype wire
